// ===== design/ebi_pkg.sv =====
// Package with shared types, constants and codes for the breakpoint envelope block.
`timescale 1ns / 1ps
package ebi_pkg;
    localparam int MaxPoints = 16;
    localparam int IdxW = $clog2(MaxPoints);
    localparam int CntW = $clog2(MaxPoints + 1);

    typedef enum logic [1:0] {
        MODE_EVAL   = 2'd0,
        MODE_APPEND = 2'd1,
        MODE_CLEAR  = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef enum logic [0:0] {
        CFG_LOOP    = 1'd0,
        CFG_CHANNEL = 1'd1
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0]         mode;
        logic [31:0]        tick;
        logic signed [23:0] point_value;
    } in_word_t;

    typedef struct packed {
        logic               value_valid;
        logic signed [23:0] envelope_value;
        logic [7:0]         channel;
        logic               point_accepted;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MOD_RD,
        ST_MOD,
        ST_RD0,
        ST_CHK0,
        ST_CHKN,
        ST_SCAN_RD,
        ST_SCAN,
        ST_MUL,
        ST_DIV,
        ST_FIN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic        start;
        logic        is_mod;
        logic [63:0] dividend;
        logic [31:0] divisor;
    } div_req_t;
endpackage

// ===== design/ebi_div.sv =====
// Shared restoring divider, one quotient bit per cycle, unsigned 64 by 32.
`timescale 1ns / 1ps
module ebi_div (
    input  logic              clk,
    input  logic              rst_n,
    input  ebi_pkg::div_req_t req,
    output logic              done,
    output logic [63:0]       quotient,
    output logic [31:0]       remainder
);
    logic [63:0] q_reg, q_next;
    logic [32:0] r_reg, r_next;
    logic [31:0] d_reg, d_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [32:0] trial;

    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done = 1'b0;
        trial = {r_reg[31:0], q_reg[63]};
        if (req.start)
        begin
            q_next = req.dividend;
            r_next = '0;
            d_next = req.divisor;
            cnt_next = req.is_mod ? 7'd32 : 7'd64;
            if (req.is_mod)
            begin
                q_next = {req.dividend[31:0], 32'd0};
            end
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 7'd0)
            begin
                busy_next = 1'b0;
                done = 1'b1;
            end
            else
            begin
                q_next = {q_reg[62:0], 1'b0};
                if (trial >= {1'b0, d_reg})
                begin
                    r_next = trial - {1'b0, d_reg};
                    q_next[0] = 1'b1;
                end
                else
                begin
                    r_next = trial;
                end
                cnt_next = cnt_reg - 7'd1;
            end
        end
    end

    assign quotient = q_reg;
    assign remainder = r_reg[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n) done |-> busy_reg);
    assert property (@(posedge clk) disable iff (!rst_n) req.start |=> busy_reg);
    assert property (@(posedge clk) disable iff (!rst_n) busy_reg |-> cnt_reg <= 7'd64);
endmodule

// ===== design/envelope_breakpoint_interpolator.sv =====
// Top level of the piecewise-linear breakpoint envelope block.
`timescale 1ns / 1ps
// Usage: input words carry a mode, a tick and a point value; each accepted
// word yields exactly one output word with the value, its valid flag, the
// configured channel and the append flag. The block takes one word at a time
// and holds stall high from acceptance until its output word is taken.
// Append, clear and unused modes reach the output register in the cycle after
// acceptance. An evaluation reads the last point, runs the wrap modulo in loop
// mode, reads the first point and checks both ends, searches the segments,
// does the interpolation multiply and division and then forms the result; the
// modulo and the division share the one serial divider with one quotient bit
// per cycle. The breakpoints sit in a memory with one write port and a
// registered read port; the segment search issues one read per cycle. Reset
// empties the table and clears the state, index and configuration registers
// but not the data registers that hold the operands and the output word; no
// clearing pass is run.
// When the receiver stalls, the output word holds and no new word is taken.
// Configuration writes go straight to the registers and should come only
// while the block is idle.
module envelope_breakpoint_interpolator (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  ebi_pkg::in_word_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output ebi_pkg::out_word_t out_data,
    input  logic               cfg_we,
    input  logic [0:0]         cfg_index,
    input  logic [7:0]         cfg_data
);
    ebi_pkg::state_t state_reg, state_next;
    logic [31:0] mem_t [ebi_pkg::MaxPoints];
    logic [23:0] mem_v [ebi_pkg::MaxPoints];
    logic [31:0] rd_t_reg;
    logic [23:0] rd_v_reg;
    logic [ebi_pkg::IdxW-1:0] rd_addr;
    logic        we;
    logic [ebi_pkg::CntW-1:0] cnt_reg, cnt_next;
    logic        loop_reg;
    logic [7:0]  chan_reg;
    logic [31:0] tick_reg, tick_next;
    logic [31:0] t0_reg, t0_next, tl_reg, tl_next;
    logic signed [24:0] v0_reg, v0_next;
    logic [ebi_pkg::CntW-1:0] idx_reg, idx_next;
    logic signed [57:0] prod_reg, prod_next;
    logic        neg_reg, neg_next;
    ebi_pkg::out_word_t out_reg, out_next;
    ebi_pkg::div_req_t dreq;
    logic        ddone;
    logic [63:0] dq;
    logic [31:0] dr;
    logic [ebi_pkg::IdxW-1:0] last_idx;
    logic signed [24:0] dv;
    logic [31:0] num;
    logic [57:0] mag;
    logic signed [25:0] res;

    assign last_idx = ebi_pkg::IdxW'(cnt_reg - ebi_pkg::CntW'(1));
    assign in_stall = (state_reg != ebi_pkg::ST_IDLE);
    assign out_valid = (state_reg == ebi_pkg::ST_OUT);
    assign out_data = out_reg;
    assign we = (state_reg == ebi_pkg::ST_IDLE) && in_valid
        && (in_data.mode == ebi_pkg::MODE_APPEND)
        && (cnt_reg != ebi_pkg::CntW'(ebi_pkg::MaxPoints));

    ebi_div u_div (
        .clk(clk), .rst_n(rst_n), .req(dreq),
        .done(ddone), .quotient(dq), .remainder(dr)
    );

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_t[cnt_reg[ebi_pkg::IdxW-1:0]] <= in_data.tick;
            mem_v[cnt_reg[ebi_pkg::IdxW-1:0]] <= in_data.point_value;
        end
        rd_t_reg <= mem_t[rd_addr];
        rd_v_reg <= mem_v[rd_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        tick_next = tick_reg;
        t0_next = t0_reg;
        tl_next = tl_reg;
        v0_next = v0_reg;
        idx_next = idx_reg;
        prod_next = prod_reg;
        neg_next = neg_reg;
        out_next = out_reg;
        rd_addr = last_idx;
        dreq = '0;
        dv = $signed({rd_v_reg[23], rd_v_reg}) - v0_reg;
        num = tick_reg - t0_reg;
        mag = prod_reg[57] ? 58'(-prod_reg) : 58'(prod_reg);
        res = 26'(v0_reg) + (neg_reg ? -$signed({1'b0, dq[24:0]}) : $signed({1'b0, dq[24:0]}));
        unique case (state_reg)
            ebi_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    out_next = '0;
                    out_next.channel = chan_reg;
                    tick_next = in_data.tick;
                    state_next = ebi_pkg::ST_OUT;
                    unique case (ebi_pkg::mode_t'(in_data.mode))
                        ebi_pkg::MODE_EVAL:
                        begin
                            if (cnt_reg != '0)
                            begin
                                state_next = ebi_pkg::ST_MOD_RD;
                            end
                        end
                        ebi_pkg::MODE_APPEND:
                        begin
                            if (we)
                            begin
                                cnt_next = cnt_reg + ebi_pkg::CntW'(1);
                                out_next.point_accepted = 1'b1;
                            end
                        end
                        ebi_pkg::MODE_CLEAR:
                        begin
                            cnt_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ebi_pkg::ST_MOD_RD:
            begin
                state_next = ebi_pkg::ST_MOD;
            end
            ebi_pkg::ST_MOD:
            begin
                tl_next = rd_t_reg;
                v0_next = $signed({rd_v_reg[23], rd_v_reg});
                if (loop_reg && cnt_reg > ebi_pkg::CntW'(1) && rd_t_reg != '0 && !idx_reg[0])
                begin
                    dreq.start = 1'b1;
                    dreq.is_mod = 1'b1;
                    dreq.dividend = {32'd0, tick_reg};
                    dreq.divisor = rd_t_reg;
                    idx_next = ebi_pkg::CntW'(1);
                end
                else if (!idx_reg[0])
                begin
                    rd_addr = '0;
                    state_next = ebi_pkg::ST_CHK0;
                end
                if (ddone)
                begin
                    tick_next = dr;
                    rd_addr = '0;
                    state_next = ebi_pkg::ST_CHK0;
                end
            end
            ebi_pkg::ST_CHK0:
            begin
                rd_addr = '0;
                state_next = ebi_pkg::ST_CHKN;
            end
            ebi_pkg::ST_CHKN:
            begin
                idx_next = '0;
                if (tick_reg <= rd_t_reg)
                begin
                    out_next.value_valid = 1'b1;
                    out_next.envelope_value = rd_v_reg;
                    state_next = ebi_pkg::ST_OUT;
                end
                else if (tick_reg >= tl_reg)
                begin
                    out_next.value_valid = 1'b1;
                    out_next.envelope_value = 24'(v0_reg);
                    state_next = ebi_pkg::ST_OUT;
                end
                else
                begin
                    t0_next = rd_t_reg;
                    v0_next = $signed({rd_v_reg[23], rd_v_reg});
                    idx_next = ebi_pkg::CntW'(1);
                    rd_addr = ebi_pkg::IdxW'(1);
                    state_next = ebi_pkg::ST_SCAN;
                end
            end
            ebi_pkg::ST_SCAN_RD:
            begin
                rd_addr = idx_reg[ebi_pkg::IdxW-1:0];
                state_next = ebi_pkg::ST_SCAN;
            end
            ebi_pkg::ST_SCAN:
            begin
                if (tick_reg >= t0_reg && tick_reg < rd_t_reg)
                begin
                    prod_next = 58'($signed({1'b0, num})) * 58'(dv);
                    tl_next = rd_t_reg - t0_reg;
                    state_next = ebi_pkg::ST_MUL;
                end
                else if (idx_reg + ebi_pkg::CntW'(1) >= cnt_reg)
                begin
                    state_next = ebi_pkg::ST_OUT;
                end
                else
                begin
                    t0_next = rd_t_reg;
                    v0_next = $signed({rd_v_reg[23], rd_v_reg});
                    idx_next = idx_reg + ebi_pkg::CntW'(1);
                    rd_addr = idx_next[ebi_pkg::IdxW-1:0];
                    state_next = ebi_pkg::ST_SCAN;
                end
            end
            ebi_pkg::ST_MUL:
            begin
                neg_next = prod_reg[57];
                dreq.start = 1'b1;
                dreq.dividend = {6'd0, mag};
                dreq.divisor = tl_reg;
                state_next = ebi_pkg::ST_DIV;
            end
            ebi_pkg::ST_DIV:
            begin
                if (ddone)
                begin
                    state_next = ebi_pkg::ST_FIN;
                end
            end
            ebi_pkg::ST_FIN:
            begin
                out_next.value_valid = 1'b1;
                out_next.envelope_value = 24'(res);
                state_next = ebi_pkg::ST_OUT;
            end
            ebi_pkg::ST_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = ebi_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ebi_pkg::ST_IDLE;
            end
        endcase
        if (state_reg == ebi_pkg::ST_IDLE)
        begin
            idx_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ebi_pkg::ST_IDLE;
            cnt_reg <= '0;
            loop_reg <= 1'b0;
            chan_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
            if (cfg_we && cfg_index == ebi_pkg::CFG_LOOP)
            begin
                loop_reg <= cfg_data[0];
            end
            if (cfg_we && cfg_index == ebi_pkg::CFG_CHANNEL)
            begin
                chan_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tick_reg <= tick_next;
        t0_reg <= t0_next;
        tl_reg <= tl_next;
        v0_reg <= v0_next;
        prod_reg <= prod_next;
        neg_reg <= neg_next;
        out_reg <= out_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= ebi_pkg::CntW'(ebi_pkg::MaxPoints));
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data));
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.channel == chan_reg);
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.value_valid && out_data.point_accepted));
endmodule
